// File: hw/rtl/glyph_template_ssd_match_assert.svh
// Assertion macros for the glyph template matcher.
`ifndef GLYPH_TEMPLATE_SSD_MATCH_ASSERT_SVH
`define GLYPH_TEMPLATE_SSD_MATCH_ASSERT_SVH
`ifndef SYNTHESIS
`define GTSM_ASSERT(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("gtsm assertion failed");
`define GTSM_NEVER(name, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("gtsm forbidden condition");
`else
`define GTSM_ASSERT(name, prop)
`define GTSM_NEVER(name, cond)
`endif
`endif

// File: hw/rtl/gtsm_pkg.sv
// Shared constants and types for the glyph template matcher.
package gtsm_pkg;

    localparam int GLYPH_COUNT = 94;
    localparam int CODE_BASE   = 32;
    localparam int BLK_ROWS    = 8;
    localparam int BLK_COLS    = 4;
    localparam int PIX_W       = 8;
    localparam int ROW_BITS    = BLK_COLS * PIX_W;
    localparam int ROW_W       = $clog2(BLK_ROWS);
    localparam int GIDX_W      = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
    localparam int STORE_ROWS  = GLYPH_COUNT * BLK_ROWS;
    localparam int ADDR_W      = $clog2(STORE_ROWS);
    localparam int CODE_W      = 7;
    localparam int SQ_W        = 2 * PIX_W;
    localparam int ROWSUM_W    = SQ_W + $clog2(BLK_COLS);
    localparam int SCORE_W     = 21;

    localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(BLK_ROWS - 1);
    localparam logic [GIDX_W-1:0] LAST_GLYPH = GIDX_W'(GLYPH_COUNT - 1);

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_BLOCK = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } state_t;

    // controller -> datapath, one template row read per cycle while scanning
    typedef struct packed {
        logic              scan_en;
        logic [GIDX_W-1:0] glyph;
        logic [ROW_W-1:0]  row;
        logic              last_row;
        logic              last_glyph;
    } scan_cmd_t;

    typedef struct packed {
        logic scan_done;
    } scan_status_t;

endpackage

// File: hw/rtl/gtsm_datapath.sv
// Template store, block buffer, SSD pipeline and best-match tracking.
module gtsm_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load_we,
    input  logic                          block_we,
    input  logic [6:0]                    glyph_index,
    input  logic [2:0]                    row_index,
    input  logic [gtsm_pkg::ROW_BITS-1:0] row_pixels,
    input  gtsm_pkg::scan_cmd_t           scan_cmd,
    output gtsm_pkg::scan_status_t        scan_status,
    output logic                          done,
    output logic [gtsm_pkg::CODE_W-1:0]   char_code,
    output logic [gtsm_pkg::SCORE_W-1:0]  match_score
);
    import gtsm_pkg::*;

    logic [ROW_BITS-1:0] store_mem [STORE_ROWS];
    logic [ROW_BITS-1:0] blk_reg [BLK_ROWS];

    logic                mem_we;
    logic [ADDR_W-1:0]   wr_addr;
    logic [ADDR_W-1:0]   rd_addr;

    // stage 1: template row and block row
    logic [ROW_BITS-1:0] tmpl_q_reg;
    logic [ROW_BITS-1:0] blk_q_reg;
    logic                v1_reg;
    logic                last_row1_reg;
    logic                last_glyph1_reg;
    logic [GIDX_W-1:0]   glyph1_reg;

    // stage 2: per-column squares
    logic [SQ_W-1:0]     sq_reg [BLK_COLS];
    logic [SQ_W-1:0]     sq_next [BLK_COLS];
    logic                v2_reg;
    logic                last_row2_reg;
    logic                last_glyph2_reg;
    logic [GIDX_W-1:0]   glyph2_reg;

    // stage 3: accumulate and compare
    logic [SCORE_W-1:0]  acc_reg;
    logic [SCORE_W-1:0]  acc_next;
    logic [SCORE_W-1:0]  best_reg;
    logic [SCORE_W-1:0]  best_next;
    logic [GIDX_W-1:0]   best_idx_reg;
    logic [GIDX_W-1:0]   best_idx_next;
    logic [ROWSUM_W-1:0] row_sum;
    logic [SCORE_W-1:0]  glyph_sum;
    logic                take;

    logic                done_reg;
    logic [CODE_W-1:0]   char_code_reg;
    logic [SCORE_W-1:0]  match_score_reg;

    assign mem_we  = load_we && (glyph_index < 7'(GLYPH_COUNT));
    assign wr_addr = ADDR_W'({glyph_index, row_index});
    assign rd_addr = ADDR_W'({scan_cmd.glyph, scan_cmd.row});

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[wr_addr] <= row_pixels;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_cmd.scan_en)
        begin
            tmpl_q_reg <= store_mem[rd_addr];
            blk_q_reg  <= blk_reg[scan_cmd.row];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < BLK_ROWS; r++)
            begin
                blk_reg[r] <= '0;
            end
        end
        else if (block_we)
        begin
            blk_reg[row_index] <= row_pixels;
        end
    end

    always_comb
    begin
        logic [PIX_W-1:0] a;
        logic [PIX_W-1:0] b;
        logic [PIX_W-1:0] d;
        for (int c = 0; c < BLK_COLS; c++)
        begin
            a          = blk_q_reg[c*PIX_W +: PIX_W];
            b          = tmpl_q_reg[c*PIX_W +: PIX_W];
            d          = (a >= b) ? (a - b) : (b - a);
            sq_next[c] = SQ_W'(d) * SQ_W'(d);
        end
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            for (int c = 0; c < BLK_COLS; c++)
            begin
                sq_reg[c] <= sq_next[c];
            end
        end
    end

    always_comb
    begin
        row_sum = '0;
        for (int c = 0; c < BLK_COLS; c++)
        begin
            row_sum = row_sum + ROWSUM_W'(sq_reg[c]);
        end
        glyph_sum     = acc_reg + SCORE_W'(row_sum);
        take          = (glyph2_reg == '0) || (glyph_sum < best_reg);
        acc_next      = acc_reg;
        best_next     = best_reg;
        best_idx_next = best_idx_reg;
        if (v2_reg)
        begin
            if (last_row2_reg)
            begin
                acc_next = '0;
                if (take)
                begin
                    best_next     = glyph_sum;
                    best_idx_next = glyph2_reg;
                end
            end
            else
            begin
                acc_next = glyph_sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg          <= 1'b0;
            last_row1_reg   <= 1'b0;
            last_glyph1_reg <= 1'b0;
            glyph1_reg      <= '0;
            v2_reg          <= 1'b0;
            last_row2_reg   <= 1'b0;
            last_glyph2_reg <= 1'b0;
            glyph2_reg      <= '0;
            acc_reg         <= '0;
            best_reg        <= '0;
            best_idx_reg    <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            v1_reg          <= scan_cmd.scan_en;
            last_row1_reg   <= scan_cmd.last_row;
            last_glyph1_reg <= scan_cmd.last_glyph;
            glyph1_reg      <= scan_cmd.glyph;
            v2_reg          <= v1_reg;
            last_row2_reg   <= last_row1_reg;
            last_glyph2_reg <= last_glyph1_reg;
            glyph2_reg      <= glyph1_reg;
            acc_reg         <= acc_next;
            best_reg        <= best_next;
            best_idx_reg    <= best_idx_next;
            done_reg        <= scan_status.scan_done;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_status.scan_done)
        begin
            char_code_reg   <= CODE_W'(CODE_BASE) + CODE_W'(best_idx_next);
            match_score_reg <= best_next;
        end
    end

    assign scan_status.scan_done = v2_reg && last_row2_reg && last_glyph2_reg;
    assign done        = done_reg;
    assign char_code   = char_code_reg;
    assign match_score = match_score_reg;

endmodule

// File: hw/rtl/gtsm_ctrl.sv
// Controller: accepts commands and sequences the template scan.
`include "glyph_template_ssd_match_assert.svh"
module gtsm_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   cmd,
    input  logic [2:0]             row_index,
    input  gtsm_pkg::scan_status_t scan_status,
    output logic                   busy,
    output logic                   load_we,
    output logic                   block_we,
    output gtsm_pkg::scan_cmd_t    scan_cmd
);
    import gtsm_pkg::*;

    state_t            state_reg;
    state_t            state_next;
    logic [GIDX_W-1:0] glyph_reg;
    logic [GIDX_W-1:0] glyph_next;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    logic              accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            glyph_reg <= '0;
            row_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            glyph_reg <= glyph_next;
            row_reg   <= row_next;
        end
    end

    always_comb
    begin
        accept     = start && (state_reg == ST_IDLE);
        busy       = (state_reg != ST_IDLE);
        load_we    = accept && (cmd == CMD_LOAD);
        block_we   = accept && (cmd == CMD_BLOCK);
        state_next = state_reg;
        glyph_next = glyph_reg;
        row_next   = row_reg;

        scan_cmd.scan_en    = 1'b0;
        scan_cmd.glyph      = glyph_reg;
        scan_cmd.row        = row_reg;
        scan_cmd.last_row   = (row_reg == LAST_ROW);
        scan_cmd.last_glyph = (glyph_reg == LAST_GLYPH);

        case (state_reg)
            ST_IDLE:
            begin
                if (block_we && (row_index == LAST_ROW))
                begin
                    state_next = ST_SCAN;
                    glyph_next = '0;
                    row_next   = '0;
                end
            end
            ST_SCAN:
            begin
                scan_cmd.scan_en = 1'b1;
                row_next         = row_reg + 1'b1;
                if (row_reg == LAST_ROW)
                begin
                    if (glyph_reg == LAST_GLYPH)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        glyph_next = glyph_reg + 1'b1;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (scan_status.scan_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `GTSM_ASSERT(a_row7_starts_scan, block_we && (row_index == LAST_ROW) |=> state_reg == ST_SCAN)
    `GTSM_ASSERT(a_scan_end_drains, (state_reg == ST_SCAN) && (row_reg == LAST_ROW) && (glyph_reg == LAST_GLYPH) |=> state_reg == ST_DRAIN)
    `GTSM_ASSERT(a_done_only_draining, scan_status.scan_done |-> state_reg == ST_DRAIN)
    `GTSM_NEVER(a_no_accept_when_busy, busy && (load_we || block_we))

endmodule

// File: hw/rtl/glyph_template_ssd_match.sv
// Top level of the glyph template SSD matcher.
// A command transfers when start is high and busy is low. A template row load
// (cmd 0) or a block row 0..6 (cmd 1) gives no result, so such commands can
// transfer on back-to-back cycles.
// Block row 7 starts a scan of all GLYPH_COUNT*8 stored template rows, one row
// per cycle through the single read port of the template memory, followed by
// read, square and accumulate pipeline stages: busy stays high until the scan
// has drained, and done pulses for one cycle with char_code and match_score
// in the first cycle with busy low again, so the next command can transfer in
// that same cycle. The receiver cannot stall and is to treat the result as
// valid only in the done cycle; the block holds it until the next scan ends.
// Reading a glyph that was never loaded gives an undefined score.
module glyph_template_ssd_match (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        cmd,
    input  logic [6:0]  glyph_index,
    input  logic [2:0]  row_index,
    input  logic [7:0]  pixel_0,
    input  logic [7:0]  pixel_1,
    input  logic [7:0]  pixel_2,
    input  logic [7:0]  pixel_3,
    output logic        done,
    output logic [6:0]  char_code,
    output logic [20:0] match_score
);
    import gtsm_pkg::*;

    scan_cmd_t           scan_cmd;
    scan_status_t        scan_status;
    logic                load_we;
    logic                block_we;
    logic [ROW_BITS-1:0] row_pixels;

    assign row_pixels = {pixel_3, pixel_2, pixel_1, pixel_0};

    gtsm_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .cmd         (cmd),
        .row_index   (row_index),
        .scan_status (scan_status),
        .busy        (busy),
        .load_we     (load_we),
        .block_we    (block_we),
        .scan_cmd    (scan_cmd)
    );

    gtsm_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .load_we     (load_we),
        .block_we    (block_we),
        .glyph_index (glyph_index),
        .row_index   (row_index),
        .row_pixels  (row_pixels),
        .scan_cmd    (scan_cmd),
        .scan_status (scan_status),
        .done        (done),
        .char_code   (char_code),
        .match_score (match_score)
    );

endmodule
